// File: hdl/mstw_pkg.sv
`default_nettype none
package mstw_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VIDX_W       = $clog2(MAX_VERTICES);
   localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
   localparam int PAIR_AW      = 2 * VIDX_W;
   localparam int CFG_W        = 7;
   localparam int CMP_W        = (VCNT_W > CFG_W) ? VCNT_W : CFG_W;
   localparam int WEIGHT_W     = 16;
   localparam int SUM_W        = 22;
   localparam int ACTION_W     = 2;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 7;

   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_VERTEX = 1'd1;

   localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 7'd64;
   localparam logic [CFG_W-1:0] START_VERTEX_RESET = 7'd1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_RUN   = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic add_read;
      logic add_write_ab;
      logic add_write_ba;
      logic run_init;
      logic scan_issue;
      logic pick;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       add_ok;
      logic       add_write;
      logic       clr_last;
      logic       start_ok;
      logic       scan_last;
      logic       found;
      logic       rsp_full;
   } status_type;

endpackage
`default_nettype wire

// File: hdl/mstw_req_if.sv
`default_nettype none
interface mstw_req_if;
   import mstw_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic [CFG_W-1:0]           end_a;
   logic [CFG_W-1:0]           end_b;
   logic signed [WEIGHT_W-1:0] edge_weight;

   modport source (output valid, action, end_a, end_b, edge_weight, input ready);
   modport sink   (input valid, action, end_a, end_b, edge_weight, output ready);
endinterface
`default_nettype wire

// File: hdl/mstw_rsp_if.sv
`default_nettype none
interface mstw_rsp_if;
   import mstw_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] tree_weight;

   modport source (output valid, tree_weight, input ready);
   modport sink   (input valid, tree_weight, output ready);
endinterface
`default_nettype wire

// File: hdl/mstw_ctrl.sv
`default_nettype none
module mstw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mstw_pkg::status_type status,
   output mstw_pkg::cmd_type         cmd
);
   import mstw_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_ADD_RD, ST_ADD_CMP, ST_ADD_WR2,
      ST_RUN_INIT, ST_SCAN, ST_SCAN_TAIL, ST_PICK, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.action)
               ACT_CLEAR: state_in = ST_CLEAR;
               ACT_ADD:   state_in = status.add_ok ? ST_ADD_RD : ST_IDLE;
               ACT_RUN:   state_in = ST_RUN_INIT;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_ADD_RD: begin
            cmd.add_read = 1'b1;
            state_in     = ST_ADD_CMP;
         end
         ST_ADD_CMP: begin
            if (status.add_write) begin
               cmd.add_write_ab = 1'b1;
               state_in         = ST_ADD_WR2;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ADD_WR2: begin
            cmd.add_write_ba = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_RUN_INIT: begin
            cmd.run_init = 1'b1;
            state_in     = status.start_ok ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) state_in = ST_SCAN_TAIL;
         end
         ST_SCAN_TAIL: state_in = ST_PICK;
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = status.found ? ST_SCAN : ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_full) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule
`default_nettype wire

// File: hdl/mstw_datapath.sv
`default_nettype none
module mstw_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [mstw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mstw_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  wire logic [mstw_pkg::ACTION_W-1:0]       req_action,
   input  wire logic [mstw_pkg::CFG_W-1:0]          req_end_a,
   input  wire logic [mstw_pkg::CFG_W-1:0]          req_end_b,
   input  wire logic signed [mstw_pkg::WEIGHT_W-1:0] req_edge_weight,
   input  wire mstw_pkg::cmd_type                   cmd,
   output mstw_pkg::status_type                     status,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [mstw_pkg::SUM_W-1:0]        rsp_tree_weight
);
   import mstw_pkg::*;

   localparam int PAIR_DEPTH = 2 ** PAIR_AW;

   // pair store: weight and presence per ordered pair
   logic signed [WEIGHT_W-1:0] pair_w_mem [PAIR_DEPTH];
   logic                       pair_p_mem [PAIR_DEPTH];
   logic signed [WEIGHT_W-1:0] best_mem   [MAX_VERTICES];

   logic [CFG_W-1:0]  vcount_ff, start_ff;
   logic [ACTION_W-1:0] action_ff;
   logic [CFG_W-1:0]  a_ff, b_ff;
   logic signed [WEIGHT_W-1:0] w_ff;

   logic [PAIR_AW-1:0] clr_cnt_ff;
   logic [CMP_W-1:0]   scan_cnt_ff;
   logic [VIDX_W-1:0]  u_ff;
   logic               s1_valid_ff;
   logic [VIDX_W-1:0]  s1_v_ff;
   logic signed [WEIGHT_W-1:0] rd_w_ff, rd_best_ff;
   logic               rd_p_ff;
   logic [MAX_VERTICES-1:0] in_tree_ff, finite_ff;
   logic               found_ff;
   logic signed [WEIGHT_W-1:0] min_ff;
   logic [VIDX_W-1:0]  pick_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic               rsp_valid_ff;
   logic signed [SUM_W-1:0] rsp_w_ff;

   logic [CMP_W-1:0]  n_act, a_ext, b_ext, s_ext, a_m1, b_m1, s_m1;
   logic [VIDX_W-1:0] a_idx, b_idx, s_idx;
   logic [PAIR_AW-1:0] rd_addr, wr_addr;
   logic               wr_en, wr_p;
   logic               cand, new_fin, better;
   logic signed [WEIGHT_W-1:0] new_best;

   always_comb begin
      n_act = (CMP_W'(vcount_ff) > CMP_W'(MAX_VERTICES)) ? CMP_W'(MAX_VERTICES)
                                                         : CMP_W'(vcount_ff);
      a_ext = CMP_W'(a_ff);
      b_ext = CMP_W'(b_ff);
      s_ext = CMP_W'(start_ff);
      a_m1  = a_ext - 1'b1;
      b_m1  = b_ext - 1'b1;
      s_m1  = s_ext - 1'b1;
      a_idx = a_m1[VIDX_W-1:0];
      b_idx = b_m1[VIDX_W-1:0];
      s_idx = s_m1[VIDX_W-1:0];

      rd_addr = cmd.add_read ? {a_idx, b_idx} : {u_ff, scan_cnt_ff[VIDX_W-1:0]};
      wr_en   = cmd.clr_step | cmd.add_write_ab | cmd.add_write_ba;
      wr_p    = !cmd.clr_step;
      if (cmd.clr_step)          wr_addr = clr_cnt_ff;
      else if (cmd.add_write_ab) wr_addr = {a_idx, b_idx};
      else                       wr_addr = {b_idx, a_idx};

      // relax the scanned vertex against the newest tree member
      cand     = s1_valid_ff && !in_tree_ff[s1_v_ff] && rd_p_ff &&
                 (!finite_ff[s1_v_ff] || (rd_w_ff < rd_best_ff));
      new_best = cand ? rd_w_ff : rd_best_ff;
      new_fin  = finite_ff[s1_v_ff] | cand;
      better   = s1_valid_ff && !in_tree_ff[s1_v_ff] && new_fin &&
                 (!found_ff || (new_best < min_ff));

      status.action    = action_type'(action_ff);
      status.add_ok    = (a_ext != '0) && (b_ext != '0) && (a_ext <= n_act) &&
                         (b_ext <= n_act) && (a_ext != b_ext);
      status.add_write = !rd_p_ff || (w_ff < rd_w_ff);
      status.clr_last  = &clr_cnt_ff;
      status.start_ok  = (s_ext != '0) && (s_ext <= n_act);
      status.scan_last = ((scan_cnt_ff + 1'b1) == n_act);
      status.found     = found_ff;
      status.rsp_full  = rsp_valid_ff;
   end

   // memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pair_p_mem[wr_addr] <= wr_p;
         pair_w_mem[wr_addr] <= w_ff;
      end
      rd_p_ff <= pair_p_mem[rd_addr];
      rd_w_ff <= pair_w_mem[rd_addr];
      if (cand) best_mem[s1_v_ff] <= rd_w_ff;
      rd_best_ff <= best_mem[scan_cnt_ff[VIDX_W-1:0]];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         a_ff      <= req_end_a;
         b_ff      <= req_end_b;
         w_ff      <= req_edge_weight;
      end
      s1_v_ff <= scan_cnt_ff[VIDX_W-1:0];
      if (cmd.run_init) u_ff <= s_idx;
      else if (cmd.pick) u_ff <= pick_ff;
      if (better) begin
         min_ff  <= new_best;
         pick_ff <= s1_v_ff;
      end
      if (cmd.rsp_load) rsp_w_ff <= sum_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VERTEX_COUNT_RESET;
         start_ff     <= START_VERTEX_RESET;
         clr_cnt_ff   <= '0;
         scan_cnt_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         in_tree_ff   <= '0;
         finite_ff    <= '0;
         found_ff     <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_VERTEX_COUNT) vcount_ff <= csr_write_data;
            if (csr_index == REG_START_VERTEX) start_ff  <= csr_write_data;
         end
         if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         s1_valid_ff <= cmd.scan_issue;
         if (cmd.run_init || cmd.pick) scan_cnt_ff <= '0;
         else if (cmd.scan_issue)      scan_cnt_ff <= scan_cnt_ff + 1'b1;
         if (cand) finite_ff[s1_v_ff] <= new_fin;
         if (cmd.run_init || cmd.pick) found_ff <= 1'b0;
         else if (better)              found_ff <= 1'b1;
         if (cmd.run_init) begin
            // seed the tree with the start vertex only
            in_tree_ff <= status.start_ok ? ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << s_idx)
                                          : '0;
            finite_ff  <= '0;
            sum_ff     <= '0;
         end else if (cmd.pick && found_ff) begin
            in_tree_ff[pick_ff] <= 1'b1;
            sum_ff <= sum_ff + SUM_W'(min_ff);
         end
         if (cmd.rsp_load)                   rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tree_weight = rsp_w_ff;

endmodule
`default_nettype wire

// File: hdl/minimum_spanning_tree_weight.sv
// Minimum spanning tree weight. Each req transaction is a clear, an edge add
// or a run. Adds keep the lowest weight per vertex pair (self loops and
// endpoints outside 1..min(vertex_count, 64) are dropped); a run grows a tree
// with Prim's algorithm from start_vertex and returns its summed weight as one
// rsp transaction, held in an output register so the next req can be taken
// while it waits. Items are processed one at a time, paced by the pair memory:
// an add is dropped at decode, or reads the stored pair and compares, then
// keeps the stored weight or writes both directions in turn; an unused action
// is dropped at decode; a clear writes all 4096 rows (one memory row per
// cycle); and a run makes one pass over the n active vertices per tree vertex,
// including the start, each pass followed by a drain and a pick step; a run
// also waits while the previous result still sits unaccepted in the output
// register. After reset the block runs the same clearing pass before it
// raises req_ch.ready; configuration writes are taken at any time but must
// only be issued while idle.
`default_nettype none
module minimum_spanning_tree_weight (
   input  wire logic                             clock,
   input  wire logic                             reset,
   mstw_req_if.sink                              req_ch,
   mstw_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_write_enable,
   input  wire logic [mstw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mstw_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import mstw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: walks clear, add and run steps
   mstw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, vertex flags, accumulator and result register
   mstw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_action       (req_ch.action),
      .req_end_a        (req_ch.end_a),
      .req_end_b        (req_ch.end_b),
      .req_edge_weight  (req_ch.edge_weight),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_tree_weight  (rsp_ch.tree_weight)
   );

endmodule
`default_nettype wire

// File: hdl/mstw_checker.sv
`default_nettype none
module mstw_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [mstw_pkg::SUM_W-1:0]       rsp_tree_weight
);
   import mstw_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_tree_weight)))
      else $error("stalled result changed");

   // clearing pass keeps input closed right after reset
   a_reset_closed: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("ready during clearing pass");

   // one transaction at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction taken while busy");

   // a result appears only at the end of a run, never while idle
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised while idle");

endmodule

bind minimum_spanning_tree_weight mstw_checker u_mstw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_tree_weight (rsp_ch.tree_weight)
);
`default_nettype wire

// File: bench/mst_checker.sv
`default_nettype none
module mst_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   mstw_req_if                                   req,
   mstw_rsp_if                                   rsp,
   input  wire logic                             csr_write_enable,
   input  wire logic [mstw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mstw_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                                    fail_count,
   output int                                    pending_sums,
   output int                                    runs_checked
);
   import mstw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic [CFG_W-1:0]           vertex_count;
   logic [CFG_W-1:0]           start_vertex;
   logic signed [WEIGHT_W-1:0] link_weight [MAX_VERTICES][MAX_VERTICES];
   bit                         link_present [MAX_VERTICES][MAX_VERTICES];
   logic signed [SUM_W-1:0]    expected_sums [$];

   function automatic int active_vertices();
      return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
   endfunction

   // Grow the tree from the start vertex; lowest-numbered vertex wins ties.
   function automatic logic signed [SUM_W-1:0] prim_tree_sum();
      int n;
      int root;
      int pick;
      int sum;
      bit joined [MAX_VERTICES];
      bit reached [MAX_VERTICES];
      int cheapest [MAX_VERTICES];
      n = active_vertices();
      sum = 0;
      root = int'(start_vertex);
      if (root < 1 || root > n) return '0;
      for (int v = 0; v < MAX_VERTICES; v++) begin
         joined[v] = 0;
         reached[v] = 0;
      end
      pick = root - 1;
      joined[pick] = 1;
      forever begin
         for (int v = 0; v < n; v++) begin
            if (!joined[v] && link_present[pick][v] &&
                (!reached[v] || int'(link_weight[pick][v]) < cheapest[v])) begin
               cheapest[v] = int'(link_weight[pick][v]);
               reached[v] = 1;
            end
         end
         pick = -1;
         for (int v = 0; v < n; v++) begin
            if (!joined[v] && reached[v] && (pick < 0 || cheapest[v] < cheapest[pick]))
               pick = v;
         end
         if (pick < 0) break;
         sum += cheapest[pick];
         joined[pick] = 1;
      end
      return sum[SUM_W-1:0];
   endfunction

   always @(posedge clock) begin
      int a;
      int b;
      int n;
      logic signed [SUM_W-1:0] want;
      if (reset) begin
         vertex_count <= VERTEX_COUNT_RESET;
         start_vertex <= START_VERTEX_RESET;
         for (int i = 0; i < MAX_VERTICES; i++)
            for (int j = 0; j < MAX_VERTICES; j++) link_present[i][j] = 0;
         expected_sums.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_VERTEX_COUNT) vertex_count <= csr_write_data;
            else if (csr_index == REG_START_VERTEX) start_vertex <= csr_write_data;
         end
         if (req.valid && req.ready) begin
            case (action_type'(req.action))
               ACT_CLEAR: begin
                  for (int i = 0; i < MAX_VERTICES; i++)
                     for (int j = 0; j < MAX_VERTICES; j++) link_present[i][j] = 0;
               end
               ACT_ADD: begin
                  n = active_vertices();
                  a = int'(req.end_a);
                  b = int'(req.end_b);
                  // drop self loops and endpoints outside the graph
                  if (a >= 1 && b >= 1 && a <= n && b <= n && a != b) begin
                     a--;
                     b--;
                     if (!link_present[a][b] || req.edge_weight < link_weight[a][b]) begin
                        link_weight[a][b] = req.edge_weight;
                        link_weight[b][a] = req.edge_weight;
                        link_present[a][b] = 1;
                        link_present[b][a] = 1;
                     end
                  end
               end
               ACT_RUN: expected_sums.insert(expected_sums.size(), prim_tree_sum());
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_sums.size() == 0) begin
               $error("unexpected tree_weight %0d", rsp.tree_weight);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_sums.pop_front();
               runs_checked <= runs_checked + 1;
               if (rsp.tree_weight !== want) begin
                  $error("tree_weight expected %0d actual %0d", want, rsp.tree_weight);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_sums <= expected_sums.size();
   end

   initial begin
      fail_count = 0;
      pending_sums = 0;
      runs_checked = 0;
   end
endmodule
`default_nettype wire

// File: bench/tb.sv
`default_nettype none
module tb;
   import mstw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    fail_count;
   int                    pending_sums;
   int                    runs_checked;
   int                    items_sent;
   bit                    steady;   // no idling on either side while set

   mstw_req_if req_if ();
   mstw_rsp_if rsp_if ();

   minimum_spanning_tree_weight dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   mst_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_sums     (pending_sums),
      .runs_checked     (runs_checked)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Stall the result side at random about 28 percent of the time, except in the steady stretch.
   always @(posedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= 28);
   end

   // Send one transaction: idle at random first, then hold valid until accepted.
   // Valid stays high into the next call, so it is never dropped and raised in one step.
   task automatic send(action_type act, int a, int b, int w);
      while (!steady && $urandom_range(99) < 28) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.end_a       <= a[CFG_W-1:0];
      req_if.end_b       <= b[CFG_W-1:0];
      req_if.edge_weight <= w[WEIGHT_W-1:0];
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   // Drain, then wait out a possible clear (4096 rows) before touching registers.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      wait (pending_sums == 0);
      repeat (4300) @(posedge clock);
   endtask

   task automatic write_regs(int count, int root);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= REG_VERTEX_COUNT;
      csr_write_data   <= count[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index        <= REG_START_VERTEX;
      csr_write_data   <= root[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Random body of one phase: mostly adds on in-range vertices, some runs and noise.
   task automatic random_phase(int count, int items, int run_pct);
      int top;
      int roll;
      int w;
      top = (count < 1) ? 1 : (count > MAX_VERTICES ? MAX_VERTICES : count);
      repeat (items) begin
         roll = $urandom_range(99);
         w = ($urandom_range(9) < 7) ? int'($urandom_range(65535))
                                     : int'($urandom_range(40)) - 20;
         if (roll < run_pct) send(ACT_RUN, 0, 0, 0);
         else if (roll < run_pct + 3) send(ACT_NONE, $urandom_range(127),
                                           $urandom_range(127), w);
         else if (roll == 99) send(ACT_CLEAR, 0, 0, 0);
         else if ($urandom_range(99) < 85)
            send(ACT_ADD, $urandom_range(1, top), $urandom_range(1, top), w);
         else send(ACT_ADD, $urandom_range(127), $urandom_range(127), w);
      end
   endtask

   initial begin
      int counts [12] = '{8, 1, 0, 127, 16, 12, 5, 2, 64, 20, 6, 64};
      int roots  [12] = '{3, 1, 1, 64, 16, 13, 0, 2, 40, 127, 1, 64};
      bit wipe   [12] = '{1, 1, 1, 1, 1, 0, 1, 1, 1, 0, 1, 1};
      reset            = 1'b1;
      steady           = 1'b0;
      items_sent       = 0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_if.valid       = 1'b0;
      req_if.action      = ACT_NONE;
      req_if.end_a       = '0;
      req_if.end_b       = '0;
      req_if.edge_weight = '0;
      rsp_if.ready       = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: weight extremes, duplicates, self loop, bad endpoints, idle action.
      send(ACT_RUN, 0, 0, 0);
      send(ACT_ADD, 1, 2, 32767);
      send(ACT_ADD, 2, 3, -32768);
      send(ACT_ADD, 1, 2, 5);
      send(ACT_ADD, 1, 2, 100);
      send(ACT_ADD, 3, 3, -7);
      send(ACT_ADD, 0, 4, -9);
      send(ACT_ADD, 4, 65, -9);
      send(ACT_ADD, 127, 127, -1);
      send(ACT_ADD, 64, 63, -32768);
      send(ACT_ADD, 63, 1, -32768);
      send(ACT_NONE, 1, 4, -100);
      send(ACT_RUN, 0, 0, 0);
      send(ACT_ADD, 3, 4, 0);
      send(ACT_ADD, 4, 1, 5);
      send(ACT_RUN, 0, 0, 0);
      send(ACT_CLEAR, 0, 0, 0);
      send(ACT_RUN, 0, 0, 0);
      send(ACT_ADD, 2, 1, 7);
      send(ACT_RUN, 0, 0, 0);

      // Phases with different register settings; some keep the old graph so a
      // shrunken vertex count meets stored edges beyond it.
      foreach (counts[p]) begin
         write_regs(counts[p], roots[p]);
         if (wipe[p]) send(ACT_CLEAR, 0, 0, 0);
         steady = (p == 4);
         random_phase(counts[p], 140, (counts[p] >= 64 || counts[p] == 0) ? 5 : 11);
      end
      steady = 1'b0;

      drain();
      $display("tb: %0d transactions sent, %0d tree weights checked over 12 settings",
               items_sent, runs_checked);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
hdl/mstw_pkg.sv
hdl/mstw_req_if.sv
hdl/mstw_rsp_if.sv
hdl/mstw_ctrl.sv
hdl/mstw_datapath.sv
hdl/minimum_spanning_tree_weight.sv
hdl/mstw_checker.sv
bench/mst_checker.sv
bench/tb.sv
